// ===== hdl/cew_pkg.sv =====
package cew_pkg;

    localparam int LIMIT_BITS_DEFAULT = 16;
    localparam int LIMIT_RESET        = 80;
    localparam int QUEUE_DEPTH        = 4;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_LIMIT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_NEWLINES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_QUOTES = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // longest output sequence: line break plus a four character hex escape
    localparam int MAX_SEQ   = 5;
    localparam int SEQ_CNT_W = 3;

    typedef struct packed {
        logic [SEQ_CNT_W-1:0]         cnt;
        logic [MAX_SEQ-1:0][7:0]      seq;
    } job_t;

    typedef struct packed {
        logic keep_newlines;
        logic escape_quotes;
    } cfg_t;

    function automatic logic [7:0] ctrl_letter(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h61; // a
            3'd1:    c = 8'h62; // b
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h6E; // n
            3'd4:    c = 8'h76; // v
            3'd5:    c = 8'h66; // f
            3'd6:    c = 8'h72; // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
        begin
            c = CH_ZERO + {4'd0, v};
        end
        else
        begin
            c = 8'h57 + {4'd0, v}; // 'a' - 10
        end
        return c;
    endfunction

endpackage

// ===== hdl/cew_ifs.sv =====
interface cew_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface cew_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

interface cew_cfg_if #(
    parameter int INDEX_W = 2,
    parameter int DATA_W  = 16
);
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/c_escape_line_wrapper_core.sv =====
// a transaction's first character passes through the job queue, the current-job register and the output register
// throughput: one output character per cycle while the result sink is ready; an item gives zero to
// five characters (optional line break plus zero, one, two or four escape characters)
// the front accepts an item every cycle while the job queue has room
// reset: asynchronous, clears column count, break flag and queue; line limit returns to 80
module c_escape_line_wrapper_core #(
    parameter int LIMIT_BITS  = cew_pkg::LIMIT_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = cew_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    cew_item_if.sink     item,
    cew_result_if.source result,
    cew_cfg_if.sink      cfg
);
    import cew_pkg::*;

    logic [LIMIT_BITS-1:0] line_limit_reg;
    cfg_t                  flags_reg;
    logic                  cfg_write;

    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;
    job_t                  wjob;
    job_t                  rjob;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= LIMIT_BITS'(LIMIT_RESET);
            flags_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                REG_LINE_LIMIT:    line_limit_reg          <= cfg.data[LIMIT_BITS-1:0];
                REG_KEEP_NEWLINES: flags_reg.keep_newlines <= cfg.data[0];
                REG_ESCAPE_QUOTES: flags_reg.escape_quotes <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    cew_front #(
        .LIMIT_BITS (LIMIT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .line_limit (line_limit_reg),
        .cfg_flags  (flags_reg),
        .full       (full),
        .push       (push),
        .job        (wjob)
    );

    cew_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wjob),
        .pop   (pop),
        .rdata (rjob),
        .full  (full),
        .empty (empty)
    );

    cew_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .rdata  (rjob),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== hdl/cew_front.sv =====
module cew_front #(
    parameter int LIMIT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cew_item_if.sink              item,
    input  logic [LIMIT_BITS-1:0] line_limit,
    input  cew_pkg::cfg_t         cfg_flags,
    input  logic                  full,
    output logic                  push,
    output cew_pkg::job_t         job
);
    import cew_pkg::*;

    localparam int CW = LIMIT_BITS + 2;

    logic signed [CW-1:0] count_reg, count_next;
    logic                 jb_reg, jb_next;

    logic [3:0][7:0]      run;
    logic signed [3:0]    run_len;
    logic [2:0]           len;
    logic                 is_nl;
    logic                 is_end;
    logic                 brk;
    logic                 accept;
    logic signed [CW-1:0] run_ext;
    logic signed [CW-1:0] n;
    logic signed [CW-1:0] lim_ext;
    logic [7:0]           ch;

    assign ch         = item.data_byte;
    assign item.ready = !full;
    assign accept     = item.valid && item.ready;

    // classify the byte into its escape run
    always_comb
    begin
        run     = '0;
        run_len = 4'sd0;
        len     = 3'd0;
        is_nl   = 1'b0;
        is_end  = 1'b0;
        if (item.mode)
        begin
            is_end = 1'b1;
        end
        else if (ch == CH_NUL)
        begin
            run[0] = CH_BSL; run[1] = CH_ZERO; len = 3'd2; run_len = 4'sd2;
        end
        else if (ch == CH_LF && cfg_flags.keep_newlines)
        begin
            is_nl   = 1'b1;
            run_len = -4'sd1;
        end
        else if (ch >= CH_BEL && ch <= CH_CR)
        begin
            run[0] = CH_BSL;
            run[1] = ctrl_letter(3'(ch - CH_BEL));
            len = 3'd2; run_len = 4'sd2;
        end
        else if ((ch == CH_QUOTE && cfg_flags.escape_quotes) || ch == CH_BSL)
        begin
            run[0] = CH_BSL; run[1] = ch; len = 3'd2; run_len = 4'sd2;
        end
        else if (ch >= CH_SPACE && ch <= CH_TILDE)
        begin
            run[0] = ch; len = 3'd1; run_len = 4'sd1;
        end
        else
        begin
            run[0] = CH_BSL;
            run[1] = CH_X;
            run[2] = hex_digit(ch[7:4]);
            run[3] = hex_digit(ch[3:0]);
            len = 3'd4; run_len = 4'sd4;
        end
    end

    assign run_ext = {{(CW-4){run_len[3]}}, run_len};
    assign n       = count_reg + run_ext;
    assign lim_ext = $signed({2'b00, line_limit});

    // wrap decision and column tracking
    always_comb
    begin
        brk        = 1'b0;
        count_next = count_reg;
        jb_next    = jb_reg;
        if (line_limit != '0)
        begin
            if (is_nl && !jb_reg)
            begin
                brk     = 1'b1;
                jb_next = 1'b1;
            end
            else if (is_end && count_reg > 0 && !jb_reg)
            begin
                brk     = 1'b1;
                jb_next = 1'b1;
            end
            else if (n < 0 || n > lim_ext)
            begin
                brk        = 1'b1;
                jb_next    = 1'b1;
                count_next = run_ext;
            end
            else
            begin
                count_next = n;
                jb_next    = 1'b0;
            end
        end
    end

    always_comb
    begin
        job.cnt    = {2'b00, brk} + len;
        job.seq[0] = brk ? CH_LF : run[0];
        job.seq[1] = brk ? run[0] : run[1];
        job.seq[2] = brk ? run[1] : run[2];
        job.seq[3] = brk ? run[2] : run[3];
        job.seq[4] = brk ? run[3] : 8'h00;
    end

    assign push = accept && (job.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            jb_reg    <= 1'b0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            jb_reg    <= jb_next;
        end
    end

endmodule

// ===== hdl/cew_queue.sv =====
module cew_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cew_pkg::job_t wdata,
    input  logic          pop,
    output cew_pkg::job_t rdata,
    output logic          full,
    output logic          empty
);
    import cew_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] fill_reg, fill_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (fill_reg == CNTW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== hdl/cew_back.sv =====
module cew_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  cew_pkg::job_t rdata,
    output logic          pop,
    cew_result_if.source  result
);
    import cew_pkg::*;

    job_t                 cur_reg, cur_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [SEQ_CNT_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;

    logic                 load_out;
    logic                 at_end;
    logic                 fin;

    // a character moves to the output register whenever it is free or draining
    assign load_out = cur_valid_reg && (!out_valid_reg || result.ready);
    assign at_end   = (idx_reg == cur_reg.cnt - 1'b1);
    assign fin      = load_out && at_end;
    assign pop      = (!cur_valid_reg || fin) && !empty;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_next       = rdata;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (fin)
        begin
            cur_valid_next = 1'b0;
        end
        else if (load_out)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_char_next  = cur_reg.seq[idx_reg];
            out_last_next  = at_end;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_char = out_char_reg;
    assign result.last     = out_last_reg;

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
